@@ src/vaud_pkg.sv @@
package vaud_pkg;

   // Stream and result field widths.
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LIMIT_W = 25;
   localparam int unsigned HDR_LEN_W = 24;

   // Configuration port geometry.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register index, taken from the word address bits of paddr.
   localparam logic [CSR_ADDR_W-3:0] REG_MAX_FRAME_LENGTH = 1'b0;

   // Reset value of the frame length limit: 16 MiB.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'h100_0000;

   // Access-unit delimiter, oldest byte first.
   localparam int unsigned DELIM_LEN = 5;
   localparam logic [BYTE_W-1:0] DELIM_PAT [DELIM_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h09};

   // Number of magic bytes that open a length-prefixed connection.
   localparam int unsigned MAGIC_LEN = 8;

   typedef enum logic {
      CMD_DATA    = 1'b0,
      CMD_RESTART = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_NOTICE  = 1'b1
   } kind_type;

   // Connection magic "XRCAM1" followed by two zero bytes.
   function automatic logic [BYTE_W-1:0] magic_byte(input logic [2:0] idx);
      logic [BYTE_W-1:0] val;
      case (idx)
         3'd0: val = 8'h58;
         3'd1: val = 8'h52;
         3'd2: val = 8'h43;
         3'd3: val = 8'h41;
         3'd4: val = 8'h4D;
         3'd5: val = 8'h31;
         default: val = 8'h00;   // the two trailing zero bytes
      endcase
      return val;
   endfunction

endpackage

@@ src/vaud_req_if.sv @@
interface vaud_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [vaud_pkg::BYTE_W-1:0]    in_byte;

   modport source (output valid, output cmd, output in_byte, input ready);
   modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

@@ src/vaud_rsp_if.sv @@
interface vaud_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           result_kind;
   logic [vaud_pkg::BYTE_W-1:0]    out_byte;
   logic                           frame_last;
   logic                           run_last;

   modport source (output valid, output result_kind, output out_byte, output frame_last,
                   output run_last, input ready);
   modport sink   (input valid, input result_kind, input out_byte, input frame_last,
                   input run_last, output ready);
endinterface

@@ src/video_access_unit_deframer_unit.sv @@
// Access-unit deframer for a received video byte stream.
// The req_ch channel carries one transfer per stream byte (cmd = 0) or a
// new-connection marker (cmd = 1). The rsp_ch channel carries at most one
// transfer per input transfer: a payload byte with its end-of-unit mark, or
// a bad-length notice. run_last is high on every result transfer.
// The first bytes of a connection are compared with the magic. On a full
// match the stream is parsed as 4-byte big-endian lengths followed by
// payload; otherwise it is cut at access-unit delimiters through a five-byte
// delay line, which is preloaded from the magic constant at the mismatch.
// An input transfer is registered and its result is offered from the output
// register. One transfer per cycle is sustained unless rsp_ch stalls; the
// rate is set by the single pass from the input register through the parser
// into the output register. A held result does not block an empty input
// register: one more item is taken while the receiver stalls, after which
// req_ch.ready drops until rsp_ch moves again. Synchronous reset empties both
// registers, returns the parser to the magic search and sets max_frame_length
// to 16 MiB. The APB-style csr port holds max_frame_length at byte address 0;
// writes take effect for items processed after them and must be issued while
// the block is idle.
module video_access_unit_deframer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   vaud_req_if.sink                             req_ch,
   vaud_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [vaud_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [vaud_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [vaud_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned BW = vaud_pkg::BYTE_W;
   localparam int unsigned LW = vaud_pkg::LIMIT_W;
   localparam int unsigned HW = vaud_pkg::HDR_LEN_W;
   localparam int unsigned WD = vaud_pkg::DELIM_LEN;

   // Framing mode of the current connection.
   typedef enum logic [1:0] {
      MODE_HUNT       = 2'd0,
      MODE_LENGTH     = 2'd1,
      MODE_START_CODE = 2'd2
   } mode_type;

   // Configuration register.
   logic [LW-1:0]       max_len_ff;
   logic                csr_sel_reg;

   // Input register.
   logic                s1_valid_ff;
   logic                s1_cmd_ff;
   logic [BW-1:0]       s1_byte_ff;

   // Parser state and its next values.
   mode_type            mode_ff, mode_in;
   logic [2:0]          magic_cnt_ff, magic_cnt_in;
   logic [2:0]          hdr_cnt_ff, hdr_cnt_in;
   logic [HW-1:0]       len_ff, len_in;
   logic [LW-1:0]       left_ff, left_in;
   logic [BW-1:0]       win_ff [WD];
   logic [BW-1:0]       win_in [WD];
   logic [2:0]          fill_ff, fill_in;
   logic                in_frame_ff, in_frame_in;

   // Output register.
   logic                rsp_valid_ff;
   logic                kind_ff, kind_in;
   logic [BW-1:0]       obyte_ff, obyte_in;
   logic                olast_ff, olast_in;
   logic                emit;

   // Pipeline control.
   logic                out_free;
   logic                step;

   // Working values of the parser.
   logic [31:0]         full_len;
   logic [LW-1:0]       left_dec;
   logic [BW-1:0]       shifted [WD];
   logic                delim_hit;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign step         = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = kind_ff;
   assign rsp_ch.out_byte    = obyte_ff;
   assign rsp_ch.frame_last  = olast_ff;
   // Every input causes at most one result, so each result closes its run.
   assign rsp_ch.run_last    = 1'b1;

   // Configuration port.
   assign csr_sel_reg = (csr_paddr[vaud_pkg::CSR_ADDR_W-1:2] == vaud_pkg::REG_MAX_FRAME_LENGTH);
   assign csr_pready  = 1'b1;
   assign csr_prdata  = csr_sel_reg ? {(vaud_pkg::CSR_DATA_W - LW)'(0), max_len_ff}
                                    : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= vaud_pkg::LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_reg) begin
         max_len_ff <= csr_pwdata[LW-1:0];
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         s1_cmd_ff  <= req_ch.cmd;
         s1_byte_ff <= req_ch.in_byte;
      end
   end

   // Delay line after the current byte is shifted in, and the delimiter test.
   always_comb begin
      for (int k = 0; k < WD - 1; k++) begin
         shifted[k] = win_ff[k+1];
      end
      shifted[WD-1] = s1_byte_ff;
      delim_hit = (fill_ff >= 3'(WD - 1));
      for (int k = 0; k < WD; k++) begin
         if (shifted[k] != vaud_pkg::DELIM_PAT[k]) begin
            delim_hit = 1'b0;
         end
      end
   end

   assign full_len = {len_ff, s1_byte_ff};
   assign left_dec = (left_ff == '0) ? '0 : left_ff - 1'b1;

   always_comb begin
      mode_in      = mode_ff;
      magic_cnt_in = magic_cnt_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      in_frame_in  = in_frame_ff;
      emit         = 1'b0;
      kind_in      = vaud_pkg::KIND_PAYLOAD;
      obyte_in     = '0;
      olast_in     = 1'b0;

      if (s1_cmd_ff == vaud_pkg::CMD_RESTART) begin
         // A new connection abandons any open unit without a result.
         mode_in      = MODE_HUNT;
         magic_cnt_in = '0;
         hdr_cnt_in   = '0;
         len_in       = '0;
         left_in      = '0;
         fill_in      = '0;
         in_frame_in  = 1'b0;
      end else begin
         case (mode_ff)
            MODE_HUNT: begin
               if (s1_byte_ff == vaud_pkg::magic_byte(magic_cnt_ff)) begin
                  if (magic_cnt_ff == 3'(vaud_pkg::MAGIC_LEN - 1)) begin
                     mode_in    = MODE_LENGTH;
                     hdr_cnt_in = '0;
                     len_in     = '0;
                  end else begin
                     magic_cnt_in = magic_cnt_ff + 1'b1;
                  end
               end else begin
                  // Replay the matched magic prefix and this byte into the
                  // delay line. No delimiter can form from them, so the
                  // replay yields no result and only loads the window.
                  mode_in = MODE_START_CODE;
                  win_in[WD-1] = s1_byte_ff;
                  for (int j = 1; j < WD; j++) begin
                     if (magic_cnt_ff >= 3'(j)) begin
                        win_in[WD-1-j] = vaud_pkg::magic_byte(magic_cnt_ff - 3'(j));
                     end
                  end
                  fill_in = (magic_cnt_ff >= 3'(WD - 1)) ? 3'(WD) : magic_cnt_ff + 1'b1;
               end
            end
            MODE_LENGTH: begin
               if (hdr_cnt_ff < 3'd4) begin
                  hdr_cnt_in = hdr_cnt_ff + 1'b1;
                  len_in     = full_len[HW-1:0];
                  if (hdr_cnt_ff == 3'd3) begin
                     len_in = '0;
                     if (full_len == '0 || full_len > {(32 - LW)'(0), max_len_ff}) begin
                        // Bad declared length: one notice, header restarts.
                        emit       = 1'b1;
                        kind_in    = vaud_pkg::KIND_NOTICE;
                        hdr_cnt_in = '0;
                     end else begin
                        left_in = full_len[LW-1:0];
                     end
                  end
               end else begin
                  emit     = 1'b1;
                  obyte_in = s1_byte_ff;
                  olast_in = (left_ff <= LW'(1));
                  left_in  = left_dec;
                  if (left_dec == '0) begin
                     hdr_cnt_in = '0;
                     len_in     = '0;
                  end
               end
            end
            MODE_START_CODE: begin
               win_in  = shifted;
               fill_in = (fill_ff < 3'(WD)) ? fill_ff + 1'b1 : fill_ff;
               if (fill_ff == 3'(WD) && in_frame_ff) begin
                  emit     = 1'b1;
                  obyte_in = win_ff[0];
                  olast_in = delim_hit;
               end
               if (delim_hit) begin
                  in_frame_in = 1'b1;
               end
            end
            default: begin
               // Unreachable mode code: data bytes are ignored.
            end
         endcase
      end
   end

   // Parser state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HUNT;
         magic_cnt_ff <= '0;
         hdr_cnt_ff   <= '0;
         len_ff       <= '0;
         left_ff      <= '0;
         fill_ff      <= '0;
         in_frame_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            mode_ff      <= mode_in;
            magic_cnt_ff <= magic_cnt_in;
            hdr_cnt_ff   <= hdr_cnt_in;
            len_ff       <= len_in;
            left_ff      <= left_in;
            fill_ff      <= fill_in;
            in_frame_ff  <= in_frame_in;
         end
         if (out_free) begin
            rsp_valid_ff <= step && emit;
         end
      end
      if (step) begin
         win_ff <= win_in;
      end
      if (step && emit) begin
         kind_ff  <= kind_in;
         obyte_ff <= obyte_in;
         olast_ff <= olast_in;
      end
   end

endmodule

@@ src/vaud_checker.sv @@
module vaud_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_result_kind,
   input logic [vaud_pkg::BYTE_W-1:0]   rsp_out_byte,
   input logic                          rsp_frame_last,
   input logic                          rsp_run_last
);

   // Each input causes at most one result, which therefore closes its run.
   a_run_last_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_last)
      else $error("result transfer without run_last");

   // A bad-length notice carries no byte and no end-of-unit mark.
   a_notice_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == vaud_pkg::KIND_NOTICE)
         |-> (rsp_out_byte == '0 && !rsp_frame_last))
      else $error("notice transfer carries payload fields");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result is held unchanged.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_out_byte) && $stable(rsp_frame_last)))
      else $error("stalled result changed");

endmodule

bind video_access_unit_deframer_unit vaud_checker u_vaud_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_result_kind (rsp_ch.result_kind),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_frame_last  (rsp_ch.frame_last),
   .rsp_run_last    (rsp_ch.run_last)
);

@@ dv/tb_video_access_unit_deframer_unit.sv @@
module tb_video_access_unit_deframer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // Parser modes of the connection, as the predictor tracks them.
   typedef enum logic [1:0] {
      MODE_SEARCH     = 2'd0,
      MODE_LENGTH     = 2'd1,
      MODE_START_CODE = 2'd2
   } link_mode_type;

   // One stream transfer on req_ch.
   typedef struct packed {
      vaud_pkg::cmd_type                cmd;
      logic [vaud_pkg::BYTE_W-1:0]      data;
   } stream_item_type;

   // One result transfer on rsp_ch.
   typedef struct packed {
      vaud_pkg::kind_type               kind;
      logic [vaud_pkg::BYTE_W-1:0]      payload;
      logic                             unit_end;
      logic                             step_end;
   } au_result_type;

   localparam int HALF_PERIOD = 1;
   localparam int RESET_CYCLES = 6;
   // Drain time, covering the input and output registers of the block with margin.
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 150;
   localparam int MAX_REPORTS = 10;
   localparam logic [vaud_pkg::LIMIT_W-1:0] LIMIT_TOP = {vaud_pkg::LIMIT_W{1'b1}};

   // Connection magic: "XRCAM1" and two zero bytes.
   localparam logic [vaud_pkg::BYTE_W-1:0] MAGIC_SEQ [vaud_pkg::MAGIC_LEN] =
      '{8'h58, 8'h52, 8'h43, 8'h41, 8'h4D, 8'h31, 8'h00, 8'h00};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [vaud_pkg::CSR_ADDR_W-1:0]    csr_paddr;
   logic [vaud_pkg::CSR_DATA_W-1:0]    csr_pwdata;
   logic [vaud_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                               csr_pready;

   vaud_req_if req_ch();
   vaud_rsp_if rsp_ch();

   video_access_unit_deframer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Stream bytes waiting to be offered, and access-unit results that the
   // predictor has worked out but the block has not yet delivered.
   stream_item_type pending_bytes [$];
   au_result_type   expected_units [$];

   int unsigned mismatch_count = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   bit          gaps_on = 1'b1;
   logic        long_hold = 1'b0;

   // Predictor copy of the deframer state and of its length limit.
   link_mode_type                      link_mode;
   logic [3:0]                         magic_hits;
   logic [2:0]                         hdr_count;
   logic [31:0]                        len_acc;
   logic [vaud_pkg::LIMIT_W-1:0]       bytes_to_go;
   logic [vaud_pkg::BYTE_W-1:0]        au_window [vaud_pkg::DELIM_LEN];
   logic [2:0]                         au_fill;
   logic                               unit_open;
   logic [vaud_pkg::LIMIT_W-1:0]       frame_limit = vaud_pkg::LIMIT_RESET;

   // Counts one failure and tells whether it is still within the report cap.
   function automatic bit count_failure();
      mismatch_count++;
      return mismatch_count <= MAX_REPORTS;
   endfunction

   // A new connection forgets everything but the length limit.
   function automatic void restart_link_model();
      link_mode = MODE_SEARCH;
      magic_hits = '0;
      hdr_count = '0;
      len_acc = '0;
      bytes_to_go = '0;
      au_fill = '0;
      unit_open = 1'b0;
      for (int i = 0; i < vaud_pkg::DELIM_LEN; i++) au_window[i] = '0;
   endfunction

   // Shifts one byte through the five-byte delimiter window. The byte that
   // falls out belongs to the open access unit, and it closes that unit when
   // the window now holds a delimiter.
   function automatic void shift_window(input logic [vaud_pkg::BYTE_W-1:0] b,
                                        ref au_result_type step_out [$]);
      logic [vaud_pkg::BYTE_W-1:0] leaving;
      logic                        was_full;
      logic                        hit;
      was_full = (au_fill >= vaud_pkg::DELIM_LEN);
      leaving = au_window[0];
      for (int i = 0; i < vaud_pkg::DELIM_LEN - 1; i++) au_window[i] = au_window[i + 1];
      au_window[vaud_pkg::DELIM_LEN - 1] = b;
      if (au_fill < vaud_pkg::DELIM_LEN) au_fill = au_fill + 3'd1;
      hit = (au_fill >= vaud_pkg::DELIM_LEN);
      for (int i = 0; i < vaud_pkg::DELIM_LEN; i++) begin
         if (au_window[i] != vaud_pkg::DELIM_PAT[i]) hit = 1'b0;
      end
      if (was_full && unit_open) begin
         step_out.push_back(au_result_type'{vaud_pkg::KIND_PAYLOAD, leaving, hit, 1'b0});
      end
      if (hit) unit_open = 1'b1;
   endfunction

   // Works out the results of one accepted stream transfer and queues them.
   function automatic void deframe_step(input stream_item_type item);
      au_result_type step_out [$];
      if (item.cmd == vaud_pkg::CMD_RESTART) begin
         restart_link_model();
         return;
      end
      case (link_mode)
         MODE_SEARCH: begin
            if (item.data == MAGIC_SEQ[magic_hits[2:0]]) begin
               magic_hits = magic_hits + 4'd1;
               if (magic_hits >= vaud_pkg::MAGIC_LEN) begin
                  link_mode = MODE_LENGTH;
                  magic_hits = 4'(vaud_pkg::MAGIC_LEN);
                  hdr_count = '0;
                  len_acc = '0;
               end
            end else begin
               // The bytes matched so far equal the magic prefix, so they are
               // replayed from the constant ahead of the offending byte.
               link_mode = MODE_START_CODE;
               for (int i = 0; i < magic_hits[2:0]; i++) shift_window(MAGIC_SEQ[i], step_out);
               shift_window(item.data, step_out);
            end
         end
         MODE_LENGTH: begin
            if (hdr_count < 3'd4) begin
               len_acc = {len_acc[23:0], item.data};
               hdr_count = hdr_count + 3'd1;
               if (hdr_count == 3'd4) begin
                  if (len_acc == 0 || len_acc > 32'(frame_limit)) begin
                     step_out.push_back(au_result_type'{vaud_pkg::KIND_NOTICE, 8'h00,
                                                        1'b0, 1'b0});
                     hdr_count = '0;
                     len_acc = '0;
                  end else begin
                     bytes_to_go = len_acc[vaud_pkg::LIMIT_W-1:0];
                  end
               end
            end else begin
               step_out.push_back(au_result_type'{vaud_pkg::KIND_PAYLOAD, item.data,
                                                  bytes_to_go <= 1, 1'b0});
               if (bytes_to_go > 0) bytes_to_go = bytes_to_go - 1'b1;
               if (bytes_to_go == 0) begin
                  hdr_count = '0;
                  len_acc = '0;
               end
            end
         end
         MODE_START_CODE: shift_window(item.data, step_out);
         default: ;
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].step_end = 1'b1;
      foreach (step_out[i]) expected_units.push_back(step_out[i]);
   endfunction

   // Stimulus building blocks.
   function automatic void put_data(input logic [vaud_pkg::BYTE_W-1:0] b);
      pending_bytes.push_back(stream_item_type'{vaud_pkg::CMD_DATA, b});
   endfunction

   // The byte that rides along with a new-connection marker is ignored, so
   // it is random.
   function automatic void put_restart();
      pending_bytes.push_back(stream_item_type'{vaud_pkg::CMD_RESTART, 8'($urandom())});
   endfunction

   function automatic void put_magic();
      foreach (MAGIC_SEQ[i]) put_data(MAGIC_SEQ[i]);
   endfunction

   function automatic void put_length(input logic [31:0] len);
      put_data(len[31:24]);
      put_data(len[23:16]);
      put_data(len[15:8]);
      put_data(len[7:0]);
   endfunction

   function automatic void put_delim();
      foreach (vaud_pkg::DELIM_PAT[i]) put_data(vaud_pkg::DELIM_PAT[i]);
   endfunction

   // Start-code content is biased toward delimiter bytes so that partial
   // delimiters show up often.
   function automatic logic [vaud_pkg::BYTE_W-1:0] noisy_byte();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h09;
         default: return 8'($urandom());
      endcase
   endfunction

   // A length-prefixed connection: mostly well-formed frames that fit the
   // current limit, with zero, over-limit, boundary and random lengths, long
   // frames cut short by a new connection, and headers broken off midway.
   function automatic void length_session(input int unsigned budget);
      int unsigned base;
      int unsigned body;
      int unsigned sel;
      logic [31:0] len;
      logic [31:0] lim;
      base = pending_bytes.size();
      lim = 32'(frame_limit);
      put_restart();
      put_magic();
      while (pending_bytes.size() - base < budget) begin
         sel = $urandom_range(0, 19);
         case (sel)
            13: len = 32'd0;
            14: len = lim + 32'd1;
            15: len = lim;
            16: len = $urandom();
            default: len = $urandom_range(1, (lim > 12) ? 12 : ((lim == 0) ? 1 : lim));
         endcase
         if (sel == 17) begin
            put_data(len[31:24]);
            put_data(len[23:16]);
            put_restart();
            put_magic();
         end else begin
            put_length(len);
            if (len != 0 && len <= lim) begin
               body = (len > 16) ? $urandom_range(1, 16) : len;
               if (sel == 18 && body > 1) body = $urandom_range(1, body - 1);
               repeat (body) put_data(8'($urandom()));
               if (body < len) begin
                  put_restart();
                  put_magic();
               end
            end
         end
      end
   endfunction

   // Start-code connections: the opening follows the magic part way and then
   // breaks off, some leading bytes follow, then a few delimited units. The
   // next connection abandons whatever unit is open.
   function automatic void start_code_session(input int unsigned budget);
      int unsigned base;
      int unsigned depth;
      logic [vaud_pkg::BYTE_W-1:0] miss;
      base = pending_bytes.size();
      while (pending_bytes.size() - base < budget) begin
         put_restart();
         depth = $urandom_range(0, vaud_pkg::MAGIC_LEN - 1);
         for (int i = 0; i < depth; i++) put_data(MAGIC_SEQ[i]);
         miss = 8'($urandom());
         if (miss == MAGIC_SEQ[depth]) miss = ~miss;
         put_data(miss);
         repeat ($urandom_range(0, 3)) put_data(noisy_byte());
         repeat ($urandom_range(1, 3)) begin
            put_delim();
            repeat ($urandom_range(0, 6)) put_data(noisy_byte());
         end
      end
   endfunction

   // Sender. A new item goes on the wire once the current one has been
   // transferred; the prediction is made from the values that were on the
   // wire at the edge of the transfer.
   always @(posedge clock) begin : drive_req
      stream_item_type taken;
      stream_item_type next_item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.cmd <= vaud_pkg::CMD_DATA;
         req_ch.in_byte <= '0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken.cmd = vaud_pkg::cmd_type'(req_ch.cmd);
            taken.data = req_ch.in_byte;
            deframe_step(taken);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gaps_on && send_gap == 0 && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(1, 18);
            end
            if (send_gap > 0 || pending_bytes.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_ch.valid <= 1'b0;
            end else begin
               next_item = pending_bytes.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.cmd <= next_item.cmd;
               req_ch.in_byte <= next_item.data;
            end
         end
      end
   end

   // Receiver. Each result transfer is checked against the oldest expected
   // result. Ready drops in random bursts, and for the whole of a long hold.
   always @(posedge clock) begin : watch_rsp
      au_result_type seen;
      au_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.kind = vaud_pkg::kind_type'(rsp_ch.result_kind);
            seen.payload = rsp_ch.out_byte;
            seen.unit_end = rsp_ch.frame_last;
            seen.step_end = rsp_ch.run_last;
            if (expected_units.size() == 0) begin
               if (count_failure()) begin
                  $display("unexpected result: kind %0d byte %02h frame_last %b run_last %b",
                           seen.kind, seen.payload, seen.unit_end, seen.step_end);
               end
            end else begin
               want = expected_units.pop_front();
               if (seen.kind !== want.kind || seen.payload !== want.payload ||
                   seen.unit_end !== want.unit_end || seen.step_end !== want.step_end) begin
                  if (count_failure()) begin
                     $display("result mismatch: expected kind %0d byte %02h frame_last %b %s %b",
                              want.kind, want.payload, want.unit_end, "run_last",
                              want.step_end);
                     $display("                 got      kind %0d byte %02h frame_last %b %s %b",
                              seen.kind, seen.payload, seen.unit_end, "run_last",
                              seen.step_end);
                  end
               end
            end
         end
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 17);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off. It starts once results are flowing while plenty
   // of stimulus is still queued, so the sender keeps offering items, the
   // block fills up and must stall its input.
   initial begin : receiver_hold
      do @(posedge clock);
      while (!(pending_bytes.size() > 30 && expected_units.size() > 0));
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin : watchdog
      #400_000;
      $display("FAILURE");
      $finish;
   end

   // Waits until every queued item has been transferred and every expected
   // result has arrived, then lets the pipeline settle, since items such as
   // leading bytes may still be in flight without any result.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_ch.valid || expected_units.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the frame length limit through the APB-style port and reads it
   // back. Only called while the block is idle.
   task automatic csr_write(input logic [vaud_pkg::LIMIT_W-1:0] value);
      logic [vaud_pkg::CSR_DATA_W-1:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {vaud_pkg::REG_MAX_FRAME_LENGTH, 2'b00};
      csr_pwdata <= vaud_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      frame_limit = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== vaud_pkg::CSR_DATA_W'(value)) begin
         if (count_failure()) begin
            $display("max_frame_length readback: expected %08h got %08h",
                     vaud_pkg::CSR_DATA_W'(value), readback);
         end
      end
   endtask

   initial begin : run_test
      req_ch.valid = 1'b0;
      req_ch.cmd = vaud_pkg::CMD_DATA;
      req_ch.in_byte = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      restart_link_model();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset limit of 16 MiB. A zero length and one
      // just above the limit each give a notice, then the shortest frame
      // carries an all-ones byte.
      put_restart();
      put_magic();
      put_length(32'd0);
      put_length(32'(vaud_pkg::LIMIT_RESET) + 32'd1);
      put_length(32'd1);
      put_data(8'hFF);
      // Early decision at the second magic byte: the replayed 'X' and the
      // bytes up to the first delimiter are dropped, then the first three
      // delimiter bytes come out as the start of a unit.
      put_restart();
      put_data(MAGIC_SEQ[0]);
      put_data(8'h00);
      put_data(8'h00);
      put_data(8'h00);
      put_data(8'h01);
      put_data(8'h09);
      put_data(8'h80);
      put_data(8'h7F);
      put_data(8'hFF);
      // A new connection in the middle of that unit abandons it silently.
      put_restart();
      wait_drained();

      // Smallest legal limit: only one-byte frames get through.
      csr_write(25'd1);
      length_session(20);
      start_code_session(15);
      wait_drained();

      // A zero limit rejects every declared length.
      csr_write(25'd0);
      length_session(10);
      wait_drained();

      // Largest value the register holds: long frames are cut short.
      csr_write(LIMIT_TOP);
      length_session(25);
      start_code_session(15);
      wait_drained();

      csr_write(vaud_pkg::LIMIT_RESET);
      length_session(20);
      wait_drained();

      // Final stretch at full rate on both sides.
      gaps_on <= 1'b0;
      csr_write(25'($urandom_range(2, 40)));
      length_session(15);
      start_code_session(15);
      wait_drained();

      if (mismatch_count == 0 && expected_units.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ video_access_unit_deframer_unit.f @@
src/vaud_pkg.sv
src/vaud_req_if.sv
src/vaud_rsp_if.sv
src/video_access_unit_deframer_unit.sv
src/vaud_checker.sv
dv/tb_video_access_unit_deframer_unit.sv
